[sv/ws_enc_pkg.sv]
package ws_enc_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_PAYLOAD = 2'd1,
    CMD_PING    = 2'd2,
    CMD_PONG    = 2'd3
  } cmd_e;

  // Longest burst one command produces: opcode, 126, two length bytes, four mask bytes
  localparam int unsigned BurstMax  = 8;
  localparam int unsigned BurstCntW = $clog2(BurstMax + 1);

  // Frame header bytes
  localparam logic [7:0] FinBit    = 8'h80;
  localparam logic [7:0] OpText    = 8'h01;
  localparam logic [7:0] OpBinary  = 8'h02;
  localparam logic [7:0] OpPing    = 8'h09;
  localparam logic [7:0] OpPong    = 8'h0a;
  localparam logic [7:0] MaskBit   = 8'h80;
  localparam logic [7:0] LenCode16 = 8'd126;

  // Lengths up to this value fit in the length byte itself
  localparam logic [15:0] LenInlineMax = 16'd125;

  // Bytes of one burst, index 0 leaves first
  typedef logic [BurstMax-1:0][7:0] burst_bytes_t;

  typedef struct packed {
    burst_bytes_t           bytes;
    logic [BurstCntW-1:0]   cnt;
    logic                   ends;   // last byte of the burst closes the frame
  } burst_t;

  // Mask byte at position pos, first byte in the top bits
  function automatic logic [7:0] mask_byte(logic [31:0] key, logic [1:0] pos);
    logic [7:0] res;
    unique case (pos)
      2'd0:    res = key[31:24];
      2'd1:    res = key[23:16];
      2'd2:    res = key[15:8];
      default: res = key[7:0];
    endcase
    return res;
  endfunction

endpackage

[sv/ws_enc_if.sv]
// Command channel into the encoder
interface ws_enc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        bin_frame;
  logic [15:0] payload_length;
  logic [31:0] mask_key;
  logic [7:0]  data_byte;

  modport source (output valid, output command, output bin_frame, output payload_length,
                  output mask_key, output data_byte, input ready);
  modport sink   (input valid, input command, input bin_frame, input payload_length,
                  input mask_key, input data_byte, output ready);
endinterface

// Wire byte channel out of the encoder
interface ws_enc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

[sv/websocket_frame_encoder_unit.sv]
// Client-side masked websocket frame encoder. Each command word is turned
// into a burst of wire bytes: a begin command gives a 6-byte header (length up
// to 125) or an 8-byte one (126 plus 16-bit length), ping and pong give a
// complete 6-byte empty control frame, and a payload byte gives one masked
// byte, so payload streams at one byte per clock while the output is not
// stalled. Output runs one byte per cycle while out_o.ready is high; one
// further command is held while a burst drains, and input stalls only when
// both that holding register and the output burst register are full. The first
// byte of a command passes through the holding register and then the output
// burst register before it shows on the output. last marks the final byte of a
// frame. Payload bytes arriving with no frame open are dropped silently.
module websocket_frame_encoder_unit (
  input logic         clk_i,
  input logic         rst_ni,
  ws_enc_in_if.sink   in_i,
  ws_enc_out_if.source out_o
);

  ws_enc_pkg::cmd_e cmd;
  logic             in_acc;

  // Frame state
  logic [31:0] mask_q, mask_d;
  logic [15:0] remain_q, remain_d;
  logic [1:0]  mpos_q, mpos_d;
  logic        open_q, open_d;

  // Burst computed from the incoming word
  ws_enc_pkg::burst_t nb;
  logic [15:0]        rem_dec;

  // Holding register between input and output
  logic               a_valid_q;
  ws_enc_pkg::burst_t a_q;
  logic               a_move;

  // Output burst register
  ws_enc_pkg::burst_bytes_t              b_bytes_q;
  logic [ws_enc_pkg::BurstCntW-1:0]      b_cnt_q;
  logic                                  b_ends_q;
  logic                                  b_free;
  logic                                  out_hs;

  assign cmd    = ws_enc_pkg::cmd_e'(in_i.command);
  assign in_acc = in_i.valid && in_i.ready;
  assign out_hs = out_o.valid && out_o.ready;

  // Output register frees when empty or its final byte leaves now
  assign b_free = (b_cnt_q == '0) ||
                  ((b_cnt_q == ws_enc_pkg::BurstCntW'(1)) && out_o.ready);
  assign a_move = a_valid_q && b_free;
  assign in_i.ready = !a_valid_q || b_free;

  // Burst and next frame state for the incoming word
  always_comb begin
    nb       = '0;
    mask_d   = mask_q;
    remain_d = remain_q;
    mpos_d   = mpos_q;
    open_d   = open_q;
    rem_dec  = remain_q - 16'd1;
    unique case (cmd)
      ws_enc_pkg::CMD_PAYLOAD: begin
        if (open_q) begin
          nb.bytes[0] = in_i.data_byte ^ ws_enc_pkg::mask_byte(mask_q, mpos_q);
          nb.cnt      = ws_enc_pkg::BurstCntW'(1);
          nb.ends     = (rem_dec == '0);
          remain_d    = rem_dec;
          mpos_d      = (rem_dec == '0) ? 2'd0 : mpos_q + 2'd1;
          open_d      = (rem_dec != '0);
        end
      end
      ws_enc_pkg::CMD_BEGIN: begin
        mask_d      = in_i.mask_key;
        mpos_d      = 2'd0;
        remain_d    = in_i.payload_length;
        open_d      = (in_i.payload_length != '0);
        nb.ends     = (in_i.payload_length == '0);
        nb.bytes[0] = ws_enc_pkg::FinBit |
                      (in_i.bin_frame ? ws_enc_pkg::OpBinary : ws_enc_pkg::OpText);
        if (in_i.payload_length > ws_enc_pkg::LenInlineMax) begin
          nb.bytes[1] = ws_enc_pkg::LenCode16 | ws_enc_pkg::MaskBit;
          nb.bytes[2] = in_i.payload_length[15:8];
          nb.bytes[3] = in_i.payload_length[7:0];
          nb.bytes[4] = in_i.mask_key[31:24];
          nb.bytes[5] = in_i.mask_key[23:16];
          nb.bytes[6] = in_i.mask_key[15:8];
          nb.bytes[7] = in_i.mask_key[7:0];
          nb.cnt      = ws_enc_pkg::BurstCntW'(8);
        end else begin
          nb.bytes[1] = in_i.payload_length[7:0] | ws_enc_pkg::MaskBit;
          nb.bytes[2] = in_i.mask_key[31:24];
          nb.bytes[3] = in_i.mask_key[23:16];
          nb.bytes[4] = in_i.mask_key[15:8];
          nb.bytes[5] = in_i.mask_key[7:0];
          nb.cnt      = ws_enc_pkg::BurstCntW'(6);
        end
      end
      ws_enc_pkg::CMD_PING, ws_enc_pkg::CMD_PONG: begin
        // Control frame also drops any open data frame
        mask_d      = in_i.mask_key;
        mpos_d      = 2'd0;
        remain_d    = '0;
        open_d      = 1'b0;
        nb.ends     = 1'b1;
        nb.bytes[0] = ws_enc_pkg::FinBit | ((cmd == ws_enc_pkg::CMD_PING) ?
                      ws_enc_pkg::OpPing : ws_enc_pkg::OpPong);
        nb.bytes[1] = ws_enc_pkg::MaskBit;
        nb.bytes[2] = in_i.mask_key[31:24];
        nb.bytes[3] = in_i.mask_key[23:16];
        nb.bytes[4] = in_i.mask_key[15:8];
        nb.bytes[5] = in_i.mask_key[7:0];
        nb.cnt      = ws_enc_pkg::BurstCntW'(6);
      end
      default: ;
    endcase
  end

  // Frame state, holding register valid and output count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      remain_q  <= '0;
      mpos_q    <= '0;
      open_q    <= 1'b0;
      a_valid_q <= 1'b0;
      b_cnt_q   <= '0;
    end else begin
      if (in_acc) begin
        mask_q   <= mask_d;
        remain_q <= remain_d;
        mpos_q   <= mpos_d;
        open_q   <= open_d;
      end
      if (in_acc) begin
        a_valid_q <= (nb.cnt != '0);
      end else if (a_move) begin
        a_valid_q <= 1'b0;
      end
      if (a_move) begin
        b_cnt_q <= a_q.cnt;
      end else if (out_hs) begin
        b_cnt_q <= b_cnt_q - ws_enc_pkg::BurstCntW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q <= nb;
    end
    if (a_move) begin
      b_bytes_q <= a_q.bytes;
      b_ends_q  <= a_q.ends;
    end else if (out_hs) begin
      b_bytes_q <= {8'h00, b_bytes_q[ws_enc_pkg::BurstMax-1:1]};
    end
  end

  assign out_o.valid    = (b_cnt_q != '0);
  assign out_o.out_byte = b_bytes_q[0];
  assign out_o.last     = b_ends_q && (b_cnt_q == ws_enc_pkg::BurstCntW'(1));

endmodule

[sv/ws_enc_checker.sv]
module ws_enc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_command_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  // A stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("output word changed while stalled");

  // Input only backs up behind pending output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no output pending");

  // A header or control command always yields output once it has left the holding register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_command_i != ws_enc_pkg::CMD_PAYLOAD)
      |=> ##1 out_valid_i)
    else $error("header command produced no output");

endmodule

bind websocket_frame_encoder_unit ws_enc_checker u_ws_enc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_command_i (in_i.command),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte_i   (out_o.out_byte),
  .out_last_i   (out_o.last)
);
